// File: rtl/cylindrical_warp_mapper_unit_macros.svh
// Assertion macros for the checker file.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef CYLINDRICAL_WARP_MAPPER_UNIT_MACROS_SVH
`define CYLINDRICAL_WARP_MAPPER_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CWM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwm checker: implication failed");

// Condition holds in every cycle out of reset.
`define CWM_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cwm checker: invariant failed");

`endif

// File: rtl/cwm_pkg.sv
package cwm_pkg;

    // Frame and field sizes
    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = 12;
    localparam int COLOR_W    = 24;
    localparam int FOCAL_W    = 24;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Register reset values
    localparam logic [FOCAL_W-1:0] FOCAL_RESET  = 24'd256000;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;

    // CORDIC arctangent: vector Q24, angle Q30 radians
    localparam int ITERATIONS    = 16;
    localparam int CORDIC_STAGES = ITERATIONS;
    localparam int V_W           = 44;
    localparam int Z_W           = 33;
    localparam int ATAN_W        = 30;
    localparam logic [ATAN_W-1:0] ATAN_Q30 [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd1
    };

    // Radius: floor(sqrt(((dx << 8)^2 + F^2) << 12)), Q14
    localparam int SQ_SUM_W    = 49;
    localparam int SQRT_SHIFT  = 12;
    localparam int SQRT_IN_W   = 62;
    localparam int ROOT_W      = 31;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int SQRT_REM_W  = 33;

    // Y offset: (F * |dy|) << 20 over the radius
    localparam int NUM_W      = FOCAL_W + COORD_W;
    localparam int NUM_SHIFT  = 20;
    localparam int NUM_FULL_W = NUM_W + NUM_SHIFT;
    localparam int QUO_W      = 26;
    localparam int DIV_STAGES = QUO_W;
    localparam int DIV_HI_W   = NUM_FULL_W - QUO_W;

    // Output placement
    localparam int X_FRAC = 38;
    localparam int Y_FRAC = 14;
    localparam int PROD_W = Z_W + FOCAL_W + 1;
    localparam int XV_W   = 59;
    localparam int YV_W   = 28;

    // Pipeline stage positions and delay-line depths, counted from the start transfer
    localparam int T_DIV_OUT      = 2 + SQRT_STAGES + DIV_STAGES;
    localparam int SIDE_DEPTH     = T_DIV_OUT;
    localparam int NUM_DEPTH      = SQRT_STAGES;
    localparam int X_SIDE_IDX     = CORDIC_STAGES + 1;
    localparam int XPOS_DEPTH     = T_DIV_OUT - CORDIC_STAGES - 2;
    localparam int RESULT_LATENCY = T_DIV_OUT + 1;

    // Per-item data that rides alongside the arithmetic
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               dx_neg;
        logic               dx_zero;
        logic               dy_neg;
    } side_t;

    // Limit a dimension register to [1, MAX_DIM]
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else if (d == '0)
            r = DIM_W'(1);
        else
            r = d;
        return r;
    endfunction

endpackage

// File: rtl/cwm_cordic.sv
module cwm_cordic import cwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [V_W-1:0] in_x,
    input  logic signed [V_W-1:0] in_y,
    output logic                  out_valid,
    output logic signed [Z_W-1:0] out_z
);

    logic                  vld_in  [CORDIC_STAGES];
    logic signed [V_W-1:0] x_in    [CORDIC_STAGES];
    logic signed [V_W-1:0] y_in    [CORDIC_STAGES];
    logic signed [Z_W-1:0] z_in    [CORDIC_STAGES];
    logic signed [V_W-1:0] x_next  [CORDIC_STAGES];
    logic signed [V_W-1:0] y_next  [CORDIC_STAGES];
    logic signed [Z_W-1:0] z_next  [CORDIC_STAGES];
    logic signed [Z_W-1:0] ang     [CORDIC_STAGES];

    logic                  vld_reg [CORDIC_STAGES];
    logic signed [V_W-1:0] x_reg   [CORDIC_STAGES-1];
    logic signed [V_W-1:0] y_reg   [CORDIC_STAGES-1];
    logic signed [Z_W-1:0] z_reg   [CORDIC_STAGES];

    // Feed each stage from the one before it
    always_comb
    begin
        vld_in[0] = in_valid;
        x_in[0]   = in_x;
        y_in[0]   = in_y;
        z_in[0]   = '0;
        for (int k = 1; k < CORDIC_STAGES; k++)
        begin
            vld_in[k] = vld_reg[k-1];
            x_in[k]   = x_reg[k-1];
            y_in[k]   = y_reg[k-1];
            z_in[k]   = z_reg[k-1];
        end
    end

    // Rotate toward the x axis, one micro-rotation per stage
    always_comb
    begin
        for (int k = 0; k < CORDIC_STAGES; k++)
        begin
            ang[k] = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_Q30[k]});
            if (!y_in[k][V_W-1])
            begin
                x_next[k] = x_in[k] + (y_in[k] >>> k);
                y_next[k] = y_in[k] - (x_in[k] >>> k);
                z_next[k] = z_in[k] + ang[k];
            end
            else
            begin
                x_next[k] = x_in[k] - (y_in[k] >>> k);
                y_next[k] = y_in[k] + (x_in[k] >>> k);
                z_next[k] = z_in[k] - ang[k];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CORDIC_STAGES; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < CORDIC_STAGES; k++)
                vld_reg[k] <= vld_in[k];
        end
    end

    // Advance vector and angle
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CORDIC_STAGES - 1; k++)
        begin
            x_reg[k] <= x_next[k];
            y_reg[k] <= y_next[k];
        end
        for (int k = 0; k < CORDIC_STAGES; k++)
            z_reg[k] <= z_next[k];
    end

    assign out_valid = vld_reg[CORDIC_STAGES-1];
    assign out_z     = z_reg[CORDIC_STAGES-1];

endmodule

// File: rtl/cwm_isqrt.sv
module cwm_isqrt import cwm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [SQRT_IN_W-1:0] in_n,
    output logic                 out_valid,
    output logic [ROOT_W-1:0]    out_root
);

    logic                  vld_in    [SQRT_STAGES];
    logic [SQRT_IN_W-1:0]  n_in      [SQRT_STAGES];
    logic [SQRT_REM_W-1:0] rem_in    [SQRT_STAGES];
    logic [ROOT_W-1:0]     root_in   [SQRT_STAGES];
    logic [SQRT_REM_W+1:0] trial_rem [SQRT_STAGES];
    logic [SQRT_REM_W+1:0] trial     [SQRT_STAGES];
    logic [SQRT_REM_W-1:0] rem_next  [SQRT_STAGES];
    logic [ROOT_W-1:0]     root_next [SQRT_STAGES];

    logic                  vld_reg   [SQRT_STAGES];
    logic [SQRT_IN_W-1:0]  n_reg     [SQRT_STAGES-1];
    logic [SQRT_REM_W-1:0] rem_reg   [SQRT_STAGES-1];
    logic [ROOT_W-1:0]     root_reg  [SQRT_STAGES];

    // Feed each stage from the one before it
    always_comb
    begin
        vld_in[0]  = in_valid;
        n_in[0]    = in_n;
        rem_in[0]  = '0;
        root_in[0] = '0;
        for (int k = 1; k < SQRT_STAGES; k++)
        begin
            vld_in[k]  = vld_reg[k-1];
            n_in[k]    = n_reg[k-1];
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
        end
    end

    // Bring in two radicand bits, settle one root bit per stage
    always_comb
    begin
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            trial_rem[k] = {rem_in[k], n_in[k][2*(ROOT_W-1-k) +: 2]};
            trial[k]     = {{(SQRT_REM_W-ROOT_W){1'b0}}, root_in[k], 2'b01};
            if (trial_rem[k] >= trial[k])
            begin
                rem_next[k]  = SQRT_REM_W'(trial_rem[k] - trial[k]);
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = trial_rem[k][SQRT_REM_W-1:0];
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
                vld_reg[k] <= vld_in[k];
        end
    end

    // Advance radicand, remainder and partial root
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQRT_STAGES - 1; k++)
        begin
            n_reg[k]   <= n_in[k];
            rem_reg[k] <= rem_next[k];
        end
        for (int k = 0; k < SQRT_STAGES; k++)
            root_reg[k] <= root_next[k];
    end

    assign out_valid = vld_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];

endmodule

// File: rtl/cwm_divide.sv
module cwm_divide import cwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [ROOT_W-1:0]   in_divisor,
    input  logic [ROOT_W-1:0]   in_hi,
    input  logic [QUO_W-1:0]    in_lo,
    output logic                out_valid,
    output logic [QUO_W-1:0]    out_quo
);

    logic              vld_in   [DIV_STAGES];
    logic [ROOT_W-1:0] d_in     [DIV_STAGES];
    logic [ROOT_W-1:0] rem_in   [DIV_STAGES];
    logic [QUO_W-1:0]  lo_in    [DIV_STAGES];
    logic [QUO_W-1:0]  q_in     [DIV_STAGES];
    logic [ROOT_W:0]   trial    [DIV_STAGES];
    logic [ROOT_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0]  q_next   [DIV_STAGES];

    logic              vld_reg  [DIV_STAGES];
    logic [ROOT_W-1:0] d_reg    [DIV_STAGES];
    logic [ROOT_W-1:0] rem_reg  [DIV_STAGES-1];
    logic [QUO_W-1:0]  lo_reg   [DIV_STAGES-1];
    logic [QUO_W-1:0]  q_reg    [DIV_STAGES];

    // Feed each stage from the one before it
    always_comb
    begin
        vld_in[0] = in_valid;
        d_in[0]   = in_divisor;
        rem_in[0] = in_hi;
        lo_in[0]  = in_lo;
        q_in[0]   = '0;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            vld_in[k] = vld_reg[k-1];
            d_in[k]   = d_reg[k-1];
            rem_in[k] = rem_reg[k-1];
            lo_in[k]  = lo_reg[k-1];
            q_in[k]   = q_reg[k-1];
        end
    end

    // Shift in one dividend bit, settle one quotient bit per stage
    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            trial[k] = {rem_in[k], lo_in[k][QUO_W-1-k]};
            if (trial[k] >= {1'b0, d_in[k]})
            begin
                rem_next[k] = ROOT_W'(trial[k] - {1'b0, d_in[k]});
                q_next[k]   = {q_in[k][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[k][ROOT_W-1:0];
                q_next[k]   = {q_in[k][QUO_W-2:0], 1'b0};
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < DIV_STAGES; k++)
                vld_reg[k] <= vld_in[k];
        end
    end

    // Advance divisor, remainder, dividend tail and quotient
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES - 1; k++)
        begin
            rem_reg[k] <= rem_next[k];
            lo_reg[k]  <= lo_in[k];
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            d_reg[k] <= d_in[k];
            q_reg[k] <= q_next[k];
        end
    end

    // A zero radius gives a zero offset
    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_quo   = (d_reg[DIV_STAGES-1] == '0) ? '0 : q_reg[DIV_STAGES-1];

endmodule

// File: rtl/cylindrical_warp_mapper_unit.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// pixel in | start, busy          | src_col, src_row, src_color
// result   | done (one cycle)     | dst_col, dst_row, dst_color
// config   | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// One pixel per cycle. The 31-stage square root and the 26-stage divider run
// in series on the row path, the longer one; the 16-stage CORDIC column path
// runs alongside and waits.
// Reset clears all valid bits and loads the register defaults.
// Nothing stalls: busy and the result side never hold an item back.
module cylindrical_warp_mapper_unit import cwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_W-1:0]    src_col,
    input  logic [COORD_W-1:0]    src_row,
    input  logic [COLOR_W-1:0]    src_color,
    output logic                  done,
    output logic [COORD_W-1:0]    dst_col,
    output logic [COORD_W-1:0]    dst_row,
    output logic [COLOR_W-1:0]    dst_color,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [FOCAL_W-1:0]    focal_reg;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;

    logic [DIM_W-1:0]      w_eff;
    logic [DIM_W-1:0]      h_eff;
    logic [COORD_W-1:0]    cx;
    logic [COORD_W-1:0]    cy;
    logic [COORD_W-1:0]    lim_w;
    logic [COORD_W-1:0]    lim_h;
    logic signed [COORD_W+1:0] dx;
    logic signed [COORD_W+1:0] dy;
    logic                  accept;
    side_t                 side_next;
    logic [COORD_W-1:0]    adx_next;
    logic [COORD_W-1:0]    ady_next;

    logic                  vld1_reg;
    logic [COORD_W-1:0]    adx1_reg;
    logic [COORD_W-1:0]    ady1_reg;
    side_t                 side_pipe_reg [SIDE_DEPTH];

    logic [2*COORD_W-1:0]  adx_sq;
    logic [2*FOCAL_W-1:0]  f_sq;
    logic [SQ_SUM_W-1:0]   sqsum_next;
    logic [NUM_W-1:0]      num_next;
    logic                  vld2_reg;
    logic [SQ_SUM_W-1:0]   sqsum2_reg;
    logic [NUM_W-1:0]      num2_reg;
    logic [NUM_W-1:0]      num_pipe_reg [NUM_DEPTH];

    logic signed [V_W-1:0] vx0;
    logic signed [V_W-1:0] vy0;
    logic                  cordic_vld;
    logic signed [Z_W-1:0] cordic_z;
    logic                  vldx_reg;
    logic signed [PROD_W-1:0] xprod_reg;
    logic signed [XV_W-1:0]   cx_term;
    logic signed [XV_W-1:0]   xprod_ext;
    logic signed [XV_W-1:0]   xv;
    logic [XV_W-X_FRAC-2:0]   xp_hi;
    logic [COORD_W-1:0]       xpos_next;
    logic [COORD_W-1:0]       xpos_pipe_reg [XPOS_DEPTH];

    logic [SQRT_IN_W-1:0]  sqrt_n;
    logic                  sqrt_vld;
    logic [ROOT_W-1:0]     sqrt_root;
    logic [NUM_FULL_W-1:0] num_full;
    logic [ROOT_W-1:0]     div_hi;
    logic [QUO_W-1:0]      div_lo;
    logic                  div_vld;
    logic [QUO_W-1:0]      div_quo;

    logic signed [YV_W-1:0]   cy_term;
    logic signed [YV_W-1:0]   yv;
    logic [YV_W-Y_FRAC-2:0]   yp_hi;
    logic [COORD_W-1:0]       ypos_next;
    side_t                    side_out;

    logic                  done_reg;
    logic [COORD_W-1:0]    dst_col_reg;
    logic [COORD_W-1:0]    dst_row_reg;
    logic [COLOR_W-1:0]    dst_color_reg;

    // Configuration registers: every transfer is taken at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg  <= FOCAL_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FOCAL:  focal_reg  <= cfg_data[FOCAL_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // Frame geometry from the registers
    assign w_eff = eff_dim(width_reg);
    assign h_eff = eff_dim(height_reg);
    assign cx    = w_eff[DIM_W-1:1];
    assign cy    = h_eff[DIM_W-1:1];
    assign lim_w = COORD_W'(w_eff - DIM_W'(1));
    assign lim_h = COORD_W'(h_eff - DIM_W'(1));

    // Stage 1: offsets from the center, magnitude and sign
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign dx     = $signed({2'b00, src_col}) - $signed({2'b00, cx});
    assign dy     = $signed({2'b00, src_row}) - $signed({2'b00, cy});

    always_comb
    begin
        adx_next          = dx[COORD_W+1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady_next          = dy[COORD_W+1] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        side_next.color   = src_color;
        side_next.dx_neg  = dx[COORD_W+1];
        side_next.dx_zero = (dx == '0);
        side_next.dy_neg  = dy[COORD_W+1];
    end

    // Stage 2: squared radius and row numerator
    always_comb
    begin
        adx_sq     = adx1_reg * adx1_reg;
        f_sq       = focal_reg * focal_reg;
        sqsum_next = SQ_SUM_W'({adx_sq, 16'b0}) + SQ_SUM_W'(f_sq);
        num_next   = focal_reg * ady1_reg;
    end

    // Hold valid bits of the front stages, the column product and the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vldx_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= accept;
            vld2_reg <= vld1_reg;
            vldx_reg <= cordic_vld;
            done_reg <= div_vld;
        end
    end

    // Payload stages and delay lines
    always_ff @(posedge clk)
    begin
        adx1_reg         <= adx_next;
        ady1_reg         <= ady_next;
        sqsum2_reg       <= sqsum_next;
        num2_reg         <= num_next;
        side_pipe_reg[0] <= side_next;
        for (int k = 1; k < SIDE_DEPTH; k++)
            side_pipe_reg[k] <= side_pipe_reg[k-1];
        num_pipe_reg[0] <= num2_reg;
        for (int k = 1; k < NUM_DEPTH; k++)
            num_pipe_reg[k] <= num_pipe_reg[k-1];
        if (cordic_vld)
            xprod_reg <= cordic_z * $signed({1'b0, focal_reg});
        if (vldx_reg)
            xpos_pipe_reg[0] <= xpos_next;
        for (int k = 1; k < XPOS_DEPTH; k++)
            xpos_pipe_reg[k] <= xpos_pipe_reg[k-1];
    end

    // Column path: arctangent of |dx| / F
    assign vx0 = $signed({{(V_W-FOCAL_W-16){1'b0}}, focal_reg, 16'b0});
    assign vy0 = $signed({{(V_W-COORD_W-24){1'b0}}, adx1_reg, 24'b0});

    cwm_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld1_reg),
        .in_x      (vx0),
        .in_y      (vy0),
        .out_valid (cordic_vld),
        .out_z     (cordic_z)
    );

    // Place the column: add center, floor, clamp to the frame
    always_comb
    begin
        cx_term   = $signed({{(XV_W-COORD_W-X_FRAC){1'b0}}, cx, {X_FRAC{1'b0}}});
        xprod_ext = XV_W'(xprod_reg);
        if (side_pipe_reg[X_SIDE_IDX].dx_zero)
            xv = cx_term;
        else if (side_pipe_reg[X_SIDE_IDX].dx_neg)
            xv = cx_term - xprod_ext;
        else
            xv = cx_term + xprod_ext;
        xp_hi = xv[XV_W-2:X_FRAC];
        if (xv[XV_W-1])
            xpos_next = '0;
        else if (xp_hi > (XV_W-X_FRAC-1)'(lim_w))
            xpos_next = lim_w;
        else
            xpos_next = xp_hi[COORD_W-1:0];
    end

    // Row path: radius, then F * |dy| << 20 over the radius
    assign sqrt_n = {1'b0, sqsum2_reg, {SQRT_SHIFT{1'b0}}};

    cwm_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld2_reg),
        .in_n      (sqrt_n),
        .out_valid (sqrt_vld),
        .out_root  (sqrt_root)
    );

    assign num_full = {num_pipe_reg[NUM_DEPTH-1], {NUM_SHIFT{1'b0}}};
    assign div_hi   = ROOT_W'(num_full[NUM_FULL_W-1:QUO_W]);
    assign div_lo   = num_full[QUO_W-1:0];

    cwm_divide u_divide
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sqrt_vld),
        .in_divisor (sqrt_root),
        .in_hi      (div_hi),
        .in_lo      (div_lo),
        .out_valid  (div_vld),
        .out_quo    (div_quo)
    );

    // Place the row: add center, floor, clamp to the frame
    assign side_out = side_pipe_reg[SIDE_DEPTH-1];

    always_comb
    begin
        cy_term = $signed({{(YV_W-COORD_W-Y_FRAC){1'b0}}, cy, {Y_FRAC{1'b0}}});
        if (side_out.dy_neg)
            yv = cy_term - $signed({{(YV_W-QUO_W){1'b0}}, div_quo});
        else
            yv = cy_term + $signed({{(YV_W-QUO_W){1'b0}}, div_quo});
        yp_hi = yv[YV_W-2:Y_FRAC];
        if (yv[YV_W-1])
            ypos_next = '0;
        else if (yp_hi > (YV_W-Y_FRAC-1)'(lim_h))
            ypos_next = lim_h;
        else
            ypos_next = yp_hi[COORD_W-1:0];
    end

    // Result register
    always_ff @(posedge clk)
    begin
        dst_col_reg   <= xpos_pipe_reg[XPOS_DEPTH-1];
        dst_row_reg   <= ypos_next;
        dst_color_reg <= side_out.color;
    end

    assign done      = done_reg;
    assign dst_col   = dst_col_reg;
    assign dst_row   = dst_row_reg;
    assign dst_color = dst_color_reg;

endmodule

// File: rtl/cwm_checker.sv
`include "cylindrical_warp_mapper_unit_macros.svh"

module cwm_checker import cwm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [COLOR_W-1:0]    src_color,
    input logic                  done,
    input logic [COLOR_W-1:0]    dst_color
);

    // Every result comes from an earlier accepted start transfer
    `CWM_ASSERT_IMPLIES(a_done_after_start, done, $past(start && !busy && rst_n, RESULT_LATENCY))

    // Color of a result is the color of the pixel that caused it
    `CWM_ASSERT_IMPLIES(a_color_through, done, dst_color == $past(src_color, RESULT_LATENCY))

    // The pipeline never holds off a pixel
    `CWM_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule

bind cylindrical_warp_mapper_unit cwm_checker u_cwm_checker (.*);
